// ===== rtl/oteq_pkg.sv =====
// Shared constants and types for the one-tap equaliser.
package oteq_pkg;

  localparam int MAX_SC      = 256;
  localparam int ADDR_W      = $clog2(MAX_SC);
  localparam int LEN_W       = ADDR_W + 1;
  localparam int SAMPLE_W    = 16;
  localparam int FRAC_W      = 4;
  localparam int PROD_W      = 2 * SAMPLE_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = LEN_W;
  localparam int IN_TDATA_W  = 4 * SAMPLE_W;
  localparam int OUT_TDATA_W = 2 * SAMPLE_W + ADDR_W;

  localparam logic [LEN_W-1:0]  LEN_MIN       = LEN_W'(2);
  localparam logic [LEN_W-1:0]  LEN_MAX       = LEN_W'(MAX_SC);
  localparam logic [LEN_W-1:0]  LEN_RESET     = LEN_W'(MAX_SC);
  localparam logic [FRAC_W-1:0] FRAC_RESET    = FRAC_W'(14);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_SUBCARRIERS = CFG_IDX_W'(0),
    REG_COEF_FRAC_BITS  = CFG_IDX_W'(1)
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
  } cplx_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    cplx_t             wr_data;
  } coef_req_t;

  typedef struct packed {
    cplx_t             sample;
    cplx_t             coef;
    logic              load;
    logic [ADDR_W-1:0] pos;
    logic              last;
  } eq_item_t;

endpackage

// ===== rtl/oteq_coef_store.sv =====
// Coefficient memory with per-entry valid bits and registered read data.
module oteq_coef_store (
  input  logic               clk,
  input  logic               rst,
  input  oteq_pkg::coef_req_t req,
  output oteq_pkg::cplx_t    rd_data,
  output logic               rd_valid
);
  import oteq_pkg::*;

  cplx_t            mem [MAX_SC];
  logic [MAX_SC-1:0] written;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.rd_en) begin
        rd_valid <= written[req.addr];
      end
      if (req.wr_en) begin
        written[req.addr] <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/oteq_datapath.sv =====
// Multiply, round and saturate pipeline with per-stage flow control.
module oteq_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  oteq_pkg::eq_item_t              in_item,
  input  oteq_pkg::cplx_t                 mem_data,
  input  logic                            mem_valid,
  input  logic [oteq_pkg::FRAC_W-1:0]     frac,
  output logic                            out_valid,
  input  logic                            out_ready,
  output oteq_pkg::cplx_t                 out_eq,
  output logic [oteq_pkg::ADDR_W-1:0]     out_pos,
  output logic                            out_last,
  output logic                            out_sat
);
  import oteq_pkg::*;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  eq_item_t          s1;
  logic signed [PROD_W-1:0] p_rr, p_ii, p_ri, p_ir;
  logic [ADDR_W-1:0] pos2, pos3;
  logic              last2, last3;
  logic signed [SUM_W-1:0] sum_re, sum_im;

  cplx_t                   coef;
  logic signed [SUM_W-1:0] rnd;
  logic signed [SUM_W-1:0] sum_re_next, sum_im_next;
  logic signed [SUM_W-1:0] sh_re, sh_im;
  cplx_t                   eq_next;
  logic                    clip_re, clip_im;

  assign en4 = !v4 || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1 && !rst;
  assign out_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_comb begin
    if (s1.load) begin
      coef = s1.coef;
    end else if (mem_valid) begin
      coef = mem_data;
    end else begin
      coef = '0;
    end
  end

  always_comb begin
    rnd = '0;
    if (frac != '0) begin
      rnd = SUM_W'(1) <<< (frac - FRAC_W'(1));
    end
    sum_re_next = SUM_W'(p_rr) - SUM_W'(p_ii) + rnd;
    sum_im_next = SUM_W'(p_ri) + SUM_W'(p_ir) + rnd;
  end

  always_comb begin
    sh_re   = sum_re >>> frac;
    sh_im   = sum_im >>> frac;
    clip_re = 1'b0;
    clip_im = 1'b0;
    if (sh_re > SUM_W'(32767)) begin
      eq_next.re = 16'sh7fff;
      clip_re    = 1'b1;
    end else if (sh_re < -SUM_W'(32768)) begin
      eq_next.re = 16'sh8000;
      clip_re    = 1'b1;
    end else begin
      eq_next.re = sh_re[SAMPLE_W-1:0];
    end
    if (sh_im > SUM_W'(32767)) begin
      eq_next.im = 16'sh7fff;
      clip_im    = 1'b1;
    end else if (sh_im < -SUM_W'(32768)) begin
      eq_next.im = 16'sh8000;
      clip_im    = 1'b1;
    end else begin
      eq_next.im = sh_im[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1 <= in_item;
    end
    if (en2) begin
      p_rr  <= s1.sample.re * coef.re;
      p_ii  <= s1.sample.im * coef.im;
      p_ri  <= s1.sample.re * coef.im;
      p_ir  <= s1.sample.im * coef.re;
      pos2  <= s1.pos;
      last2 <= s1.last;
    end
    if (en3) begin
      sum_re <= sum_re_next;
      sum_im <= sum_im_next;
      pos3   <= pos2;
      last3  <= last2;
    end
    if (en4) begin
      out_eq   <= eq_next;
      out_pos  <= pos3;
      out_last <= last3;
      out_sat  <= clip_re || clip_im;
    end
  end

endmodule

// ===== rtl/ofdm_one_tap_equalizer_unit.sv =====
// One-tap zero-forcing equaliser: position tracking, coefficient store and datapath.
// Pipeline: the input item is registered in s1, then the products, the sums and the output register.
// Throughput: one item per cycle unless stalled; one store read, at most one write each.
// Stalls: ready passes back combinationally, so bubbles fill while a result waits.
// Reset: position and load flag cleared, all coefficients read as zero, registers
// num_subcarriers = 256 and coef_frac_bits = 14; no clearing pass is needed.
module ofdm_one_tap_equalizer_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // sample_re, sample_im, coef_re, coef_im
  input  logic [oteq_pkg::IN_TDATA_W-1:0]     s_tdata,
  // sym_load
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // eq_re, eq_im, subcarrier
  output logic [oteq_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                m_tlast,
  // saturated
  output logic                                m_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [oteq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [oteq_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import oteq_pkg::*;

  logic [LEN_W-1:0]  num_sc;
  logic [FRAC_W-1:0] frac;
  logic [ADDR_W-1:0] position;
  logic              loading;

  logic [LEN_W-1:0]  len;
  logic              accept;
  logic              load_now;
  logic              last;
  coef_req_t         req;
  eq_item_t          item;
  cplx_t             mem_data;
  logic              mem_valid;
  cplx_t             eq;
  logic [ADDR_W-1:0] out_pos;

  assign cfg_ready = !rst;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    if (num_sc < LEN_MIN) begin
      len = LEN_MIN;
    end else if (num_sc > LEN_MAX) begin
      len = LEN_MAX;
    end else begin
      len = num_sc;
    end
    load_now = (position == '0) ? s_tuser : loading;
    last     = LEN_W'(position) >= (len - LEN_W'(1));

    item.sample.re = s_tdata[SAMPLE_W-1:0];
    item.sample.im = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
    item.coef.re   = s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
    item.coef.im   = s_tdata[4*SAMPLE_W-1:3*SAMPLE_W];
    item.load      = load_now;
    item.pos       = position;
    item.last      = last;

    req.rd_en   = accept;
    req.wr_en   = accept && load_now;
    req.addr    = position;
    req.wr_data = item.coef;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_sc   <= LEN_RESET;
      frac     <= FRAC_RESET;
      position <= '0;
      loading  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NUM_SUBCARRIERS: num_sc <= cfg_data;
          REG_COEF_FRAC_BITS:  frac   <= cfg_data[FRAC_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (position == '0) begin
          loading <= s_tuser;
        end
        position <= last ? '0 : position + ADDR_W'(1);
      end
    end
  end

  oteq_coef_store u_store (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rd_data  (mem_data),
    .rd_valid (mem_valid)
  );

  oteq_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (item),
    .mem_data  (mem_data),
    .mem_valid (mem_valid),
    .frac      (frac),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_eq    (eq),
    .out_pos   (out_pos),
    .out_last  (m_tlast),
    .out_sat   (m_tuser)
  );

  assign m_tdata = {out_pos, eq.im, eq.re};

endmodule

// ===== tb/ofdm_one_tap_equalizer_unit_tb.sv =====
// Self-checking testbench for the one-tap equaliser: directed and random subcarrier streams.
module ofdm_one_tap_equalizer_unit_tb;
  import oteq_pkg::*;

  typedef struct {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic [ADDR_W-1:0]          subcarrier;
    logic                       last;
    logic                       saturated;
  } eq_result_t;

  logic                     clk;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  // sample_re, sample_im, coef_re, coef_im
  logic [IN_TDATA_W-1:0]    s_tdata;
  // sym_load
  logic                     s_tuser;
  logic                     m_tvalid;
  logic                     m_tready;
  // eq_re, eq_im, subcarrier
  logic [OUT_TDATA_W-1:0]   m_tdata;
  logic                     m_tlast;
  // saturated
  logic                     m_tuser;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  logic signed [SAMPLE_W-1:0] coef_store_re [MAX_SC];
  logic signed [SAMPLE_W-1:0] coef_store_im [MAX_SC];
  logic [ADDR_W-1:0]          sc_pos;
  logic                       loading;
  logic [CFG_DATA_W-1:0]      num_sc;
  logic [FRAC_W-1:0]          frac_bits;

  eq_result_t pending_eq[$];
  int fail_count = 0;
  int items_sent = 0;
  int src_idle_pct = 23;
  int sink_idle_pct = 23;

  ofdm_one_tap_equalizer_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int symbol_len();
    if (num_sc < 2) return 2;
    if (num_sc > MAX_SC) return MAX_SC;
    return int'(num_sc);
  endfunction

  // round half up, shift, clip; bit 16 flags clipping
  function automatic logic [16:0] round_sat(input longint v, input logic [FRAC_W-1:0] f);
    longint acc;
    acc = v;
    if (f != 0) acc += longint'(1) << (f - 4'd1);
    acc = acc >>> f;
    if (acc > 32767) return {1'b1, 16'h7fff};
    if (acc < -32768) return {1'b1, 16'h8000};
    return {1'b0, acc[15:0]};
  endfunction

  function automatic eq_result_t equalise_subcarrier(input logic signed [SAMPLE_W-1:0] sr,
                                                     input logic signed [SAMPLE_W-1:0] si,
                                                     input logic fs,
                                                     input logic signed [SAMPLE_W-1:0] cr_new,
                                                     input logic signed [SAMPLE_W-1:0] ci_new);
    eq_result_t r;
    longint cr;
    longint ci;
    logic [16:0] re_q;
    logic [16:0] im_q;
    if (sc_pos == 0) loading = fs;
    if (loading) begin
      coef_store_re[sc_pos] = cr_new;
      coef_store_im[sc_pos] = ci_new;
    end
    cr = longint'(coef_store_re[sc_pos]);
    ci = longint'(coef_store_im[sc_pos]);
    re_q = round_sat(longint'(sr) * cr - longint'(si) * ci, frac_bits);
    im_q = round_sat(longint'(sr) * ci + longint'(si) * cr, frac_bits);
    r.re = re_q[15:0];
    r.im = im_q[15:0];
    r.subcarrier = sc_pos;
    r.last = int'(sc_pos) >= symbol_len() - 1;
    r.saturated = re_q[16] | im_q[16];
    sc_pos = r.last ? '0 : sc_pos + 1'b1;
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_s16();
    int w;
    logic [SAMPLE_W-1:0] v;
    w = $urandom_range(16, 1);
    v = 16'($urandom);
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return $signed(v) >>> (16 - w);
    endcase
  endfunction

  task automatic send_subcarrier(input logic signed [SAMPLE_W-1:0] sr,
                                 input logic signed [SAMPLE_W-1:0] si,
                                 input logic fs,
                                 input logic signed [SAMPLE_W-1:0] cr,
                                 input logic signed [SAMPLE_W-1:0] ci);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {ci, cr, si, sr};
    s_tuser  <= fs;
    do @(posedge clk); while (!s_tready);
    pending_eq.push_back(equalise_subcarrier(sr, si, fs, cr, ci));
    items_sent++;
  endtask

  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (pending_eq.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_NUM_SUBCARRIERS) num_sc = val;
    else if (idx == REG_COEF_FRAC_BITS) frac_bits = val[FRAC_W-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // the load flag is honoured at position 0 only; elsewhere it is occasional noise
  task automatic send_run(input int count, input int load_pct);
    logic load_sym;
    load_sym = 1'b0;
    for (int j = 0; j < count; j++) begin
      if (sc_pos == 0) load_sym = $urandom_range(99) < load_pct;
      send_subcarrier(rand_s16(), rand_s16(),
                      (sc_pos == 0) ? load_sym : ($urandom_range(19) == 0),
                      rand_s16(), rand_s16());
    end
  endtask

  task automatic test_unloaded_store();
    send_subcarrier(16'sh7fff, 16'sh8000, 1'b0, 16'sd1234, -16'sd1234);
    send_subcarrier(16'sh8000, 16'sh7fff, 1'b1, 16'sh7fff, 16'sh7fff);
    send_subcarrier(-16'sd1, 16'sd1, 1'b0, 16'sh8000, 16'sh8000);
    // shorten the symbol while mid-way through it
    program_reg(REG_NUM_SUBCARRIERS, 9'd2);
    send_subcarrier(16'sd100, -16'sd100, 1'b0, 16'sd0, 16'sd0);
  endtask

  task automatic test_extreme_products();
    program_reg(REG_NUM_SUBCARRIERS, 9'd4);
    program_reg(REG_COEF_FRAC_BITS, 9'd0);
    send_subcarrier(16'sh7fff, 16'sh8000, 1'b1, 16'sh8000, 16'sh7fff);
    send_subcarrier(16'sh8000, 16'sh8000, 1'b0, 16'sh8000, 16'sh8000);
    send_subcarrier(16'sd0, 16'sd0, 1'b0, 16'sh7fff, 16'sh7fff);
    send_subcarrier(16'sd1, -16'sd1, 1'b1, 16'sd1, 16'sd0);
    program_reg(REG_COEF_FRAC_BITS, 9'd15);
    send_subcarrier(16'sh8000, 16'sh7fff, 1'b0, 16'sh7fff, 16'sh8000);
    send_subcarrier(16'sh7fff, 16'sh7fff, 1'b0, 16'sd0, 16'sd0);
    send_subcarrier(16'sh7fff, 16'sh8000, 1'b0, 16'sh8000, 16'sh8000);
    send_subcarrier(-16'sd3, 16'sd5, 1'b0, 16'sd9, -16'sd9);
  endtask

  task automatic test_length_limits();
    program_reg(REG_COEF_FRAC_BITS, {5'h1f, 4'd14});
    program_reg(REG_NUM_SUBCARRIERS, 9'd0);
    send_subcarrier(16'sd16384, 16'sd0, 1'b1, 16'sd16384, -16'sd16384);
    send_subcarrier(-16'sd20000, 16'sd12345, 1'b0, 16'sh8000, 16'sh7fff);
    program_reg(REG_NUM_SUBCARRIERS, 9'd511);
    send_subcarrier(16'sd1000, 16'sd2000, 1'b0, 16'sd0, 16'sd0);
    send_subcarrier(16'sh8000, 16'sh8000, 1'b0, 16'sd0, 16'sd0);
  endtask

  task automatic test_ignored_register();
    program_reg(REG_NUM_SUBCARRIERS, 9'd3);
    for (int i = int'(REG_COEF_FRAC_BITS) + 1; i < 2 ** CFG_IDX_W; i++)
      program_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    send_subcarrier(16'sd7777, -16'sd7777, 1'b0, 16'sd1, 16'sd1);
    send_subcarrier(16'sd300, 16'sd400, 1'b1, 16'sd8192, 16'sd8192);
    send_subcarrier(-16'sd300, 16'sd400, 1'b0, -16'sd8192, 16'sd4096);
  endtask

  task automatic test_random_symbols(input int item_goal);
    int goal;
    int eff;
    int n;
    logic [CFG_DATA_W-1:0] len_val;
    logic [FRAC_W-1:0] frac_val;
    goal = items_sent + item_goal;
    while (items_sent < goal) begin
      case ($urandom_range(15))
        0: len_val = CFG_DATA_W'($urandom_range(1));
        1: len_val = CFG_DATA_W'($urandom_range(511, 257));
        2: len_val = 9'd256;
        default: len_val = CFG_DATA_W'($urandom_range(24, 2));
      endcase
      case ($urandom_range(3))
        0: frac_val = '0;
        1: frac_val = '1;
        default: frac_val = FRAC_W'($urandom);
      endcase
      program_reg(REG_NUM_SUBCARRIERS, len_val);
      program_reg(REG_COEF_FRAC_BITS, {(CFG_DATA_W - FRAC_W)'($urandom), frac_val});
      if ($urandom_range(3) == 0)
        program_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1,
                                               int'(REG_COEF_FRAC_BITS) + 1)),
                    CFG_DATA_W'($urandom));
      eff = symbol_len();
      n = (eff > 32) ? eff : eff * $urandom_range(3, 1);
      if ($urandom_range(4) == 0) n = $urandom_range(2 * eff, 1);
      send_run(n, 40);
    end
  endtask

  task automatic test_streaming_no_gaps();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    program_reg(REG_NUM_SUBCARRIERS, 9'd256);
    program_reg(REG_COEF_FRAC_BITS, 9'd14);
    send_run(256, 100);
    send_run(100, 0);
    drain_pipeline();
    src_idle_pct = 23;
    sink_idle_pct = 23;
  endtask

  initial begin : check_results
    eq_result_t want;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (pending_eq.size() == 0) begin
          $error("result transfer with nothing expected: tdata %h", m_tdata);
          fail_count++;
        end else begin
          want = pending_eq.pop_front();
          if ($signed(m_tdata[15:0]) !== want.re) begin
            $error("eq_re: expected %0d, actual %0d", want.re, $signed(m_tdata[15:0]));
            fail_count++;
          end
          if ($signed(m_tdata[31:16]) !== want.im) begin
            $error("eq_im: expected %0d, actual %0d", want.im, $signed(m_tdata[31:16]));
            fail_count++;
          end
          if (m_tdata[39:32] !== want.subcarrier) begin
            $error("subcarrier: expected %0d, actual %0d", want.subcarrier, m_tdata[39:32]);
            fail_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last_of_symbol: expected %0b, actual %0b", want.last, m_tlast);
            fail_count++;
          end
          if (m_tuser !== want.saturated) begin
            $error("saturated: expected %0b, actual %0b", want.saturated, m_tuser);
            fail_count++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    foreach (coef_store_re[i]) begin
      coef_store_re[i] = '0;
      coef_store_im[i] = '0;
    end
    sc_pos    = '0;
    loading   = 1'b0;
    num_sc    = 9'd256;
    frac_bits = 4'd14;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_unloaded_store();
    test_extreme_products();
    test_length_limits();
    test_ignored_register();
    test_random_symbols(220);
    test_streaming_no_gaps();
    test_random_symbols(30);

    drain_pipeline();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
